FILE: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/cofl_pkg.sv
// types, codes and constants of the frame acceptance filter
package cofl_pkg;

	localparam int unsigned DEF_BLOCK_DEPTH = 16;
	localparam int unsigned ID_W            = 11;
	localparam int unsigned CLASS_W         = 4;
	localparam int unsigned COUNT_OUT_W     = 5;
	localparam int unsigned MASK_W          = 9;
	localparam int unsigned CFG_W           = 11;

	localparam logic        LOG_EN_RESET     = 1'b1;
	localparam logic [10:0] ONLY_ID_RESET    = 11'd0;
	localparam logic [8:0]  CLASS_MASK_RESET = 9'd446;

	// function-code field of the identifier
	localparam logic [10:0] FC_MASK     = 11'h780;
	localparam logic [10:0] FC_HB       = 11'h700;
	localparam logic [10:0] FC_TPDO1    = 11'h180;
	localparam logic [10:0] FC_TPDO2    = 11'h280;
	localparam logic [10:0] FC_TPDO3    = 11'h380;
	localparam logic [10:0] FC_TPDO4    = 11'h480;
	localparam logic [10:0] FC_RPDO1    = 11'h200;
	localparam logic [10:0] FC_RPDO2    = 11'h300;
	localparam logic [10:0] FC_RPDO3    = 11'h400;
	localparam logic [10:0] FC_RPDO4    = 11'h500;
	localparam logic [10:0] FC_SDO_RESP = 11'h580;
	localparam logic [10:0] FC_SDO_REQ  = 11'h600;
	localparam logic [10:0] FC_EMCY     = 11'h080;
	localparam logic [10:0] ID_NMT      = 11'h000;
	localparam logic [10:0] ID_SYNC     = 11'h080;

	typedef enum logic [1:0] {
		FN_CHECK = 2'd0,
		FN_ADD   = 2'd1,
		FN_DEL   = 2'd2
	} cofl_func_t;

	typedef enum logic [1:0] {
		REG_LOG_ENABLE = 2'd0,
		REG_ONLY_ID    = 2'd1,
		REG_CLASS_MASK = 2'd2
	} cofl_reg_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} cofl_status_t;

	typedef enum logic [3:0] {
		CLS_HB       = 4'd0,
		CLS_TPDO     = 4'd1,
		CLS_RPDO     = 4'd2,
		CLS_SDO_RESP = 4'd3,
		CLS_SDO_REQ  = 4'd4,
		CLS_NMT      = 4'd5,
		CLS_SYNC     = 4'd6,
		CLS_EMCY     = 4'd7,
		CLS_OTHER    = 4'd8
	} cofl_class_t;

	// operation broadcast to every cell of the list
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            add;
		logic            del;
	} cofl_cmd_t;

	function automatic cofl_class_t class_of(input logic [ID_W-1:0] id);
		logic [ID_W-1:0] fc;
		cofl_class_t     cls;
		fc = id & FC_MASK;
		if (fc == FC_HB)
			cls = CLS_HB;
		else if (fc == FC_TPDO1 || fc == FC_TPDO2 || fc == FC_TPDO3 || fc == FC_TPDO4)
			cls = CLS_TPDO;
		else if (fc == FC_RPDO1 || fc == FC_RPDO2 || fc == FC_RPDO3 || fc == FC_RPDO4)
			cls = CLS_RPDO;
		else if (fc == FC_SDO_RESP)
			cls = CLS_SDO_RESP;
		else if (fc == FC_SDO_REQ)
			cls = CLS_SDO_REQ;
		else if (id == ID_NMT)
			cls = CLS_NMT;
		else if (id == ID_SYNC)
			cls = CLS_SYNC;
		else if (fc == FC_EMCY)
			cls = CLS_EMCY;
		else
			cls = CLS_OTHER;
		return cls;
	endfunction

endpackage

FILE: hw/rtl/cofl_cell.sv
// one blocklist entry with its compare and shift-down logic
module cofl_cell (
	input  logic                           clk,
	input  cofl_pkg::cofl_cmd_t            cmd,
	input  logic                           in_use,
	input  logic                           at_tail,
	input  logic                           list_hit,
	input  logic                           hit_in,
	input  logic [cofl_pkg::ID_W-1:0]      next_entry,
	output logic                           hit_out,
	output logic [cofl_pkg::ID_W-1:0]      entry
);

	logic [cofl_pkg::ID_W-1:0] entry_q;
	logic                      hit_here;

	assign hit_here = in_use && (entry_q == cmd.id);
	// true from the matching cell onward along the row
	assign hit_out  = hit_in || hit_here;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.del && hit_out) begin
			entry_q <= next_entry;
		end else if (cmd.add && !list_hit && at_tail) begin
			entry_q <= cmd.id;
		end
	end

endmodule

FILE: hw/rtl/canopen_frame_log_filter.sv
// top level of the frame acceptance filter with identifier blocklist
//
// Input channel s_*: one item per operation. s_tdata carries the 11-bit
// identifier, s_tuser the operation (check frame, add or delete a blocked
// identifier) and the remote request flag. Output channel m_*: one result
// item per input item with the accept flag, the frame class, the blocklist
// fill count and the operation status.
// The blocklist is a row of cells, one identifier each; every cell compares
// its entry with the operand, and a hit flag runs along the row so that on a
// delete each cell at or after the match loads its right neighbor's entry.
// The result is registered in the output register; throughput is one item
// per cycle while the receiver takes results, as the compare along the cell
// row is combinational.
// When the receiver stalls the result stays in the output register and
// s_tready drops until it is taken. Reset clears the list count and the
// output valid and loads the register defaults; configuration writes via
// cfg_we, cfg_index and cfg_data take effect at the next edge.
module canopen_frame_log_filter #(
	parameter int unsigned BLOCK_DEPTH = cofl_pkg::DEF_BLOCK_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [cofl_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // cob_id[10:0], zero pad
	input  logic [2:0]                   s_tuser,  // func[1:0], rtr[2]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// accept[0], frame_class[4:1], list_count[9:5], op_status[11:10], zero pad
	output logic [15:0]                  m_tdata
);

	localparam int unsigned CW = $clog2(BLOCK_DEPTH + 1);

	logic                              log_en_q;
	logic [cofl_pkg::ID_W-1:0]         only_id_q;
	logic [cofl_pkg::MASK_W-1:0]       class_mask_q;
	logic [CW-1:0]                     count_q;

	logic                              out_valid_q;
	logic                              accept_q;
	cofl_pkg::cofl_class_t             class_q;
	logic [CW-1:0]                     count_out_q;
	cofl_pkg::cofl_status_t            status_q;

	logic                              take;
	cofl_pkg::cofl_func_t              func;
	logic [cofl_pkg::ID_W-1:0]         in_id;
	logic                              in_rtr;
	cofl_pkg::cofl_class_t             cls;
	cofl_pkg::cofl_cmd_t               cmd;
	logic                              list_hit;
	logic                              full;
	logic                              ok;
	cofl_pkg::cofl_status_t            status;
	logic [CW-1:0]                     count_nxt;

	logic [BLOCK_DEPTH:0]              hit;
	logic [BLOCK_DEPTH-1:0]            in_use;
	logic [BLOCK_DEPTH-1:0]            at_tail;
	logic [cofl_pkg::ID_W-1:0]         entry [BLOCK_DEPTH];

	assign func   = cofl_pkg::cofl_func_t'(s_tuser[1:0]);
	assign in_rtr = s_tuser[2];
	assign in_id  = s_tdata[cofl_pkg::ID_W-1:0];
	assign cls    = cofl_pkg::class_of(in_id);

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	assign cmd.id   = in_id;
	assign cmd.add  = take && (func == cofl_pkg::FN_ADD);
	assign cmd.del  = take && (func == cofl_pkg::FN_DEL);

	assign hit[0]   = 1'b0;
	assign list_hit = hit[BLOCK_DEPTH];
	assign full     = (count_q == CW'(BLOCK_DEPTH));

	for (genvar k = 0; k < BLOCK_DEPTH; k++) begin : g_cell
		logic [cofl_pkg::ID_W-1:0] nxt;
		assign in_use[k]  = (CW'(k) < count_q);
		assign at_tail[k] = (count_q == CW'(k));
		if (k == BLOCK_DEPTH - 1) begin : g_last
			assign nxt = entry[k];
		end else begin : g_mid
			assign nxt = entry[k+1];
		end
		cofl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.in_use     (in_use[k]),
			.at_tail    (at_tail[k]),
			.list_hit   (list_hit),
			.hit_in     (hit[k]),
			.next_entry (nxt),
			.hit_out    (hit[k+1]),
			.entry      (entry[k])
		);
	end

	always_comb begin
		ok        = 1'b0;
		status    = cofl_pkg::ST_DONE;
		count_nxt = count_q;
		unique case (func)
			cofl_pkg::FN_CHECK: begin
				ok = !in_rtr && log_en_q
					&& (only_id_q == '0 || in_id == only_id_q)
					&& !list_hit && class_mask_q[cls];
			end
			cofl_pkg::FN_ADD: begin
				if (list_hit)
					status = cofl_pkg::ST_DUPLICATE;
				else if (full)
					status = cofl_pkg::ST_FULL;
				else
					count_nxt = count_q + CW'(1);
			end
			cofl_pkg::FN_DEL: begin
				if (!list_hit)
					status = cofl_pkg::ST_NOT_FOUND;
				else
					count_nxt = count_q - CW'(1);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_en_q     <= cofl_pkg::LOG_EN_RESET;
			only_id_q    <= cofl_pkg::ONLY_ID_RESET;
			class_mask_q <= cofl_pkg::CLASS_MASK_RESET;
		end else if (cfg_we) begin
			unique case (cofl_pkg::cofl_reg_t'(cfg_index))
				cofl_pkg::REG_LOG_ENABLE: log_en_q     <= cfg_data[0];
				cofl_pkg::REG_ONLY_ID:    only_id_q    <= cfg_data[cofl_pkg::ID_W-1:0];
				cofl_pkg::REG_CLASS_MASK: class_mask_q <= cfg_data[cofl_pkg::MASK_W-1:0];
				default:                  log_en_q     <= log_en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accept_q    <= ok;
			class_q     <= cls;
			count_out_q <= count_nxt;
			status_q    <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, status_q, cofl_pkg::COUNT_OUT_W'(count_out_q), class_q, accept_q};

endmodule

FILE: hw/rtl/cofl_checker.sv
// port-level checks of the frame acceptance filter, bound to the top level
`include "assert_macros.svh"

module cofl_checker #(
	parameter int unsigned BLOCK_DEPTH = cofl_pkg::DEF_BLOCK_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// every accepted item shows its result at the next edge
	`ASSERT_NEXT(a_one_cycle, clk, arst_n, s_tvalid && s_tready, m_tvalid)

	// an accepted frame is a plain check, never a list operation with a fault
	`ASSERT_IMPL(a_accept_done, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[11:10] == 2'd0)

	// fill count never passes the list depth
	`ASSERT_IMPL(a_count_range, clk, arst_n, m_tvalid,
		(BLOCK_DEPTH > 31) || (32'(m_tdata[9:5]) <= BLOCK_DEPTH))

endmodule

bind canopen_frame_log_filter cofl_checker #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_cofl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/cofl_filter_checker.sv
// checker for the frame acceptance filter: mirrors the filter state, predicts and compares results
module cofl_filter_checker
	import cofl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [15:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [15:0]         m_tdata,
	output int                  fail_count,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = DEF_BLOCK_DEPTH;

	typedef struct packed {
		logic         accept;
		cofl_class_t  cls;
		logic [4:0]   count;
		cofl_status_t status;
	} verdict_t;

	logic              log_en;
	logic [ID_W-1:0]   only_id;
	logic [MASK_W-1:0] class_mask;
	logic [ID_W-1:0]   blocklist[$];
	verdict_t          expected_verdicts[$];

	function automatic cofl_class_t id_class(input logic [ID_W-1:0] id);
		cofl_class_t c;
		case (id & FC_MASK)
			FC_HB: c = CLS_HB;
			FC_TPDO1, FC_TPDO2, FC_TPDO3, FC_TPDO4: c = CLS_TPDO;
			FC_RPDO1, FC_RPDO2, FC_RPDO3, FC_RPDO4: c = CLS_RPDO;
			FC_SDO_RESP: c = CLS_SDO_RESP;
			FC_SDO_REQ: c = CLS_SDO_REQ;
			// sync sits inside the emergency range
			FC_EMCY: c = (id == ID_SYNC) ? CLS_SYNC : CLS_EMCY;
			default: c = (id == ID_NMT) ? CLS_NMT : CLS_OTHER;
		endcase
		return c;
	endfunction

	// applies one operation to the mirrored list and returns its result
	function automatic verdict_t next_verdict(input logic [1:0] fn, input logic [ID_W-1:0] id,
			input logic rtr);
		verdict_t v;
		int       hit;
		v.accept = 1'b0;
		v.cls    = id_class(id);
		v.status = ST_DONE;
		hit = -1;
		foreach (blocklist[k])
			if (hit < 0 && blocklist[k] == id)
				hit = k;
		case (fn)
			FN_CHECK: begin
				v.accept = !rtr && log_en && (only_id == '0 || id == only_id) && hit < 0
					&& class_mask[int'(v.cls)];
			end
			FN_ADD: begin
				if (hit >= 0)
					v.status = ST_DUPLICATE;
				else if (blocklist.size() < LIST_DEPTH)
					blocklist.push_back(id);
				else
					v.status = ST_FULL;
			end
			FN_DEL: begin
				if (hit < 0)
					v.status = ST_NOT_FOUND;
				else
					blocklist.delete(hit);
			end
			default: ;
		endcase
		v.count = 5'(blocklist.size());
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			log_en     = LOG_EN_RESET;
			only_id    = ONLY_ID_RESET;
			class_mask = CLASS_MASK_RESET;
			blocklist.delete();
			expected_verdicts.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result item with no expectation: m_tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tdata[0] !== want.accept) begin
						$error("accept: expected %0d, actual %0d", want.accept, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[4:1] !== want.cls) begin
						$error("frame_class: expected %0d, actual %0d", want.cls, m_tdata[4:1]);
						fail_count++;
					end
					if (m_tdata[9:5] !== want.count) begin
						$error("list_count: expected %0d, actual %0d", want.count, m_tdata[9:5]);
						fail_count++;
					end
					if (m_tdata[11:10] !== want.status) begin
						$error("op_status: expected %0d, actual %0d", want.status,
							m_tdata[11:10]);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LOG_ENABLE: log_en = cfg_data[0];
					REG_ONLY_ID:    only_id = cfg_data[ID_W-1:0];
					REG_CLASS_MASK: class_mask = cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_verdicts.push_back(next_verdict(s_tuser[1:0], s_tdata[ID_W-1:0],
					s_tuser[2]));
			outstanding <= expected_verdicts.size();
		end
	end

endmodule

FILE: tb/tb_canopen_frame_log_filter.sv
// testbench top for the frame acceptance filter: stimulus, stalls and final verdict
module tb_canopen_frame_log_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import cofl_pkg::*;

	// func code with no operation behind it
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_LOG_ENABLE;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;  // cob_id[10:0], zero pad
	logic [2:0]        s_tuser = '0;  // func[1:0], rtr[2]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// accept[0], frame_class[4:1], list_count[9:5], op_status[11:10], zero pad
	logic [15:0]       m_tdata;
	int                fail_count;
	int                outstanding;
	logic              calm = 1'b0;

	always #5 clk = ~clk;

	canopen_frame_log_filter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	cofl_filter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	task automatic send_op(input logic [1:0] fn, input logic [ID_W-1:0] id, input logic rtr);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, id};
		s_tuser  <= {rtr, fn};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_filter(input logic en, input logic [ID_W-1:0] only,
			input logic [MASK_W-1:0] mask);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOG_ENABLE;
		cfg_data  <= {10'd0, en};
		@(posedge clk);
		cfg_index <= REG_ONLY_ID;
		cfg_data  <= only;
		@(posedge clk);
		cfg_index <= REG_CLASS_MASK;
		cfg_data  <= {2'd0, mask};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ids come mostly from a small pool so adds, deletes and checks hit each other
	task automatic run_phase(input int n_items, input logic [ID_W-1:0] favored);
		logic [ID_W-1:0] pool[POOL_SIZE];
		logic [ID_W-1:0] id;
		logic [1:0]      fn;
		int              mode;
		int              r;
		foreach (pool[k])
			pool[k] = 11'($urandom_range(0, 2047));
		pool[0] = favored;
		pool[1] = favored;
		pool[2] = ID_NMT;
		pool[3] = ID_SYNC;
		pool[4] = 11'h7FF;
		mode = 0;
		for (int n = 0; n < n_items; n++) begin
			if (n % 24 == 0)
				mode = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			case (mode)
				0: fn = (r < 70) ? FN_ADD : (r < 75) ? FN_DEL : FN_CHECK;    // fill
				1: fn = (r < 15) ? FN_ADD : (r < 65) ? FN_DEL : FN_CHECK;    // drain
				default: fn = (r < 10) ? FN_ADD : (r < 20) ? FN_DEL : FN_CHECK;
			endcase
			if ($urandom_range(0, 39) == 0)
				fn = FN_UNUSED;
			if ($urandom_range(0, 7) == 0)
				id = 11'($urandom_range(0, 2047));
			else
				id = pool[$urandom_range(0, POOL_SIZE - 1)];
			send_op(fn, id, $urandom_range(0, 4) == 0);
		end
	endtask

	initial begin : ready_gen
		int run_len;
		int stall;
		forever begin
			m_tready <= 1'b1;
			run_len = $urandom_range(1, 30);
			repeat (run_len) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(1, 9);
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [ID_W-1:0]   rnd_only;
		logic [MASK_W-1:0] rnd_mask;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: heartbeat and sync classes are off
		send_op(FN_CHECK, 11'h000, 1'b0);
		send_op(FN_CHECK, 11'h080, 1'b0);
		send_op(FN_CHECK, 11'h081, 1'b0);
		send_op(FN_CHECK, 11'h700, 1'b0);
		send_op(FN_CHECK, 11'h77F, 1'b0);
		send_op(FN_CHECK, 11'h7FF, 1'b0);
		send_op(FN_CHECK, 11'h181, 1'b0);
		send_op(FN_CHECK, 11'h201, 1'b0);
		send_op(FN_CHECK, 11'h5FF, 1'b0);
		send_op(FN_CHECK, 11'h67F, 1'b0);
		send_op(FN_CHECK, 11'h100, 1'b0);
		send_op(FN_CHECK, 11'h181, 1'b1);
		send_op(FN_ADD, 11'h181, 1'b0);
		send_op(FN_ADD, 11'h181, 1'b0);
		send_op(FN_CHECK, 11'h181, 1'b0);
		send_op(FN_DEL, 11'h7FF, 1'b0);
		send_op(FN_ADD, 11'h7FF, 1'b0);
		send_op(FN_ADD, 11'h000, 1'b1);
		send_op(FN_DEL, 11'h181, 1'b0);
		send_op(FN_CHECK, 11'h7FF, 1'b0);
		send_op(FN_DEL, 11'h7FF, 1'b0);
		send_op(FN_DEL, 11'h000, 1'b0);
		send_op(FN_UNUSED, 11'h7FF, 1'b1);
		send_op(FN_ADD, 11'h555, 1'b1);

		set_filter(1'b1, ONLY_ID_RESET, CLASS_MASK_RESET);
		run_phase(240, 11'($urandom_range(0, 2047)));
		set_filter(1'b1, 11'h000, 9'h1FF);
		run_phase(260, 11'($urandom_range(0, 2047)));
		set_filter(1'b0, 11'h7FF, 9'h1FF);
		run_phase(150, 11'h7FF);
		set_filter(1'b1, 11'h7FF, 9'h1FF);
		run_phase(200, 11'h7FF);
		set_filter(1'b1, 11'h001, 9'h000);
		run_phase(150, 11'h001);
		rnd_only = 11'($urandom_range(1, 2047));
		rnd_mask = 9'($urandom_range(0, 511));
		set_filter(1'b1, rnd_only, rnd_mask);
		run_phase(300, rnd_only);
		rnd_mask = 9'($urandom_range(0, 511));
		set_filter(1'b1, 11'h000, rnd_mask);
		run_phase(300, 11'($urandom_range(0, 2047)));
		calm <= 1'b1;
		set_filter(1'b1, 11'h000, 9'h1FF);
		run_phase(350, 11'($urandom_range(0, 2047)));

		drain_results();
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("tb_canopen_frame_log_filter OK");
		else
			$display("tb_canopen_frame_log_filter NOT OK");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_canopen_frame_log_filter NOT OK");
		$finish;
	end

endmodule
